// ----- design/sst_pkg.sv -----
// ----------------------------------------------------------------------------
// sst_pkg
// Types and constants shared by the small set table and its channel
// interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package sst_pkg;

  localparam int CMD_W  = 2;
  localparam int VAL_W  = 32;
  localparam int CNT_W  = 5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  // word index of the capacity register (paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MOVE,
    ST_EMIT
  } sst_state_t;

endpackage

`default_nettype wire

// ----- design/sst_req_if.sv -----
// ----------------------------------------------------------------------------
// sst_req_if
// Command channel: one word carries an operation code and a signed value.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_req_if import sst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

// ----- design/sst_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sst_rsp_if
// Result channel: search outcome, entry count and insert refusal flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sst_rsp_if import sst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [CNT_W-1:0] position;
  logic [CNT_W-1:0] count;
  logic             full_error;

  modport source (output valid, output found, output position, output count,
                  output full_error, input ready);
  modport sink   (input valid, input found, input position, input count,
                  input full_error, output ready);
endinterface

`default_nettype wire

// ----- design/small_set_table_top.sv -----
// ----------------------------------------------------------------------------
// small_set_table_top
// Set of distinct 32-bit values kept packed in a single-port-read memory.
// Sequencing: the search reads memory one slot at a time, a delete that
//   moves the last entry into the freed slot passes through a move state,
//   and the result then goes through the output register stage.
// One command is taken at a time: a new one is accepted only back in the
//   idle state, so the linear search limits the rate; a stalled result holds the sequencer.
// Reset: synchronous; count clears to 0, capacity limit returns to 16,
//   memory contents are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module small_set_table_top
  import sst_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire                clk,
  input  wire                rst,
  sst_req_if.sink            req,
  sst_rsp_if.source          rsp,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [APB_AW-1:0]   paddr,
  input  wire [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIM_MAX = (DEPTH < 31) ? DEPTH : 31;
  localparam logic [CNT_W-1:0] LIM_TOP = CNT_W'(LIM_MAX);

  // memory
  logic [VAL_W-1:0] mem [DEPTH];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // control and payload registers
  sst_state_t       state, state_next;
  logic [CMD_W-1:0] cmd_q;
  logic [VAL_W-1:0] key_q;
  logic [CNT_W-1:0] cmp_idx, cmp_idx_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [CNT_W-1:0] cap;
  logic             res_found, res_found_next;
  logic [CNT_W-1:0] res_pos, res_pos_next;
  logic             res_err, res_err_next;
  logic             out_valid;
  logic             out_found;
  logic [CNT_W-1:0] out_pos;
  logic [CNT_W-1:0] out_cnt;
  logic             out_err;

  logic             accept;
  logic             load_out;
  logic             hit;
  logic             last;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] eff_lim;
  logic             cfg_wr;

  assign accept  = req.valid && req.ready;
  assign cnt_m1  = cnt - 5'd1;
  assign hit     = (cnt != '0) && (rd_data == key_q);
  assign last    = (cnt == '0) || (cmp_idx == cnt_m1);
  assign eff_lim = (cap > LIM_TOP) ? LIM_TOP : cap;

  // APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wr) begin
      cap <= pwdata[CNT_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (hit || last) begin
          if ((cmd_q == CMD_DELETE) && hit && (cmp_idx != cnt_m1)) begin
            state_next = ST_MOVE;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_MOVE: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid || rsp.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = AW'(cnt);
    mem_wdata      = key_q;
    mem_raddr      = '0;
    cmp_idx_next   = cmp_idx;
    cnt_next       = cnt;
    res_found_next = res_found;
    res_pos_next   = res_pos;
    res_err_next   = res_err;
    load_out       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready    = 1'b1;
        cmp_idx_next = '0;
      end
      ST_SEARCH: begin
        if (hit || last) begin
          res_found_next = hit;
          res_pos_next   = hit ? cmp_idx : cnt;
          res_err_next   = 1'b0;
          case (cmd_q)
            CMD_INSERT: begin
              if (!hit) begin
                if (cnt < eff_lim) begin
                  mem_we    = 1'b1;
                  mem_waddr = AW'(cnt);
                  mem_wdata = key_q;
                  cnt_next  = cnt + 5'd1;
                end else begin
                  res_err_next = 1'b1;
                end
              end
            end
            CMD_DELETE: begin
              if (hit) begin
                if (cmp_idx == cnt_m1) begin
                  cnt_next = cnt_m1;
                end else begin
                  mem_raddr = AW'(cnt_m1);
                end
              end
            end
            default: ;
          endcase
        end else begin
          cmp_idx_next = cmp_idx + 5'd1;
          mem_raddr    = AW'(cmp_idx + 5'd1);
        end
      end
      ST_MOVE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(res_pos);
        mem_wdata = rd_data;
        cnt_next  = cnt_m1;
      end
      ST_EMIT: begin
        load_out = !out_valid || rsp.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= req.cmd;
      key_q <= req.value;
    end
    cmp_idx   <= cmp_idx_next;
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
    res_err   <= res_err_next;
    if (load_out) begin
      out_found <= res_found;
      out_pos   <= res_pos;
      out_cnt   <= cnt;
      out_err   <= res_err;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.found      = out_found;
  assign rsp.position   = out_pos;
  assign rsp.count      = out_cnt;
  assign rsp.full_error = out_err;

endmodule

`default_nettype wire

// ----- sim/small_set_table_top_tb.sv -----
// ----------------------------------------------------------------------------
// small_set_table_top_tb
// Self-checking bench for the small set table. Commands go in on the request
// channel with bursty timing while the result channel stalls on its own
// pattern. A local copy of the table predicts every result word, and each
// one is compared field by field. Directed runs cover empty and full tables,
// extreme values and capacity edges. Random phases follow, each after its own
// write of the capacity setting.
// ----------------------------------------------------------------------------
`default_nettype none

module small_set_table_top_tb;
  import sst_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int CLK_PERIOD  = 12;
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [APB_AW-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};

  typedef struct packed {
    logic             found;
    logic [CNT_W-1:0] position;
    logic [CNT_W-1:0] count;
    logic             full_error;
  } set_result_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_STALLS} sink_mode_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  sst_req_if req_ch ();
  sst_rsp_if rsp_ch ();

  small_set_table_top #(.DEPTH(TABLE_DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted table contents
  logic [VAL_W-1:0] table_slots [TABLE_DEPTH];
  logic [CNT_W-1:0] table_count;
  logic [CNT_W-1:0] capacity_reg;

  set_result_t      expected_results [$];
  int               mismatches;
  int               burst_left;
  bit               quiet_sender;
  logic [VAL_W-1:0] value_pool [20];

  sink_mode_t sink_mode;
  int         sink_tick;
  int         stall_left;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * 1000000);
    $display("FAILURE");
    $finish;
  end

  function automatic set_result_t apply_command(input logic [CMD_W-1:0] c,
                                                input logic [VAL_W-1:0] v);
    set_result_t      r;
    logic [CNT_W-1:0] lim;
    lim = (capacity_reg > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : capacity_reg;
    r = '0;
    r.position = table_count;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!r.found && i < table_count && table_slots[i] == v) begin
        r.found    = 1'b1;
        r.position = CNT_W'(i);
      end
    end
    case (c)
      CMD_INSERT: begin
        if (!r.found) begin
          if (table_count < lim) begin
            table_slots[table_count] = v;
            table_count++;
          end else begin
            r.full_error = 1'b1;
          end
        end
      end
      CMD_DELETE: begin
        if (r.found) begin
          table_slots[r.position] = table_slots[table_count - 1];
          table_count--;
        end
      end
      default: ;
    endcase
    r.count = table_count;
    return r;
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] c, input logic signed [VAL_W-1:0] v);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (quiet_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid = 1'b1;
    req_ch.cmd   = c;
    req_ch.value = v;
    do @(posedge clk); while (!req_ch.ready);
    expected_results.push_back(apply_command(c, v));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid = 1'b0;
    burst_left   = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [APB_DW-1:0] data);
    wait_idle();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = CAP_ADDR;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    capacity_reg = data[CNT_W-1:0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // result sink: ready pattern switches mode every so often
  always @(negedge clk) begin
    sink_tick++;
    if (sink_tick % 97 == 0) sink_mode = sink_mode_t'($urandom_range(0, 2));
    case (sink_mode)
      RDY_ALWAYS: rsp_ch.ready = 1'b1;
      RDY_COIN:   rsp_ch.ready = 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          rsp_ch.ready = 1'b0;
        end else begin
          rsp_ch.ready = 1'b1;
          stall_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 15) : 0;
        end
      end
    endcase
  end

  always @(posedge clk) begin
    set_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with none expected");
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
          mismatches++;
        end
        if (rsp_ch.position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, rsp_ch.position);
          mismatches++;
        end
        if (rsp_ch.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp_ch.count);
          mismatches++;
        end
        if (rsp_ch.full_error !== want.full_error) begin
          $error("full_error: expected %0d, got %0d", want.full_error, rsp_ch.full_error);
          mismatches++;
        end
      end
    end
  end

  task automatic test_basic_ops();
    send_word(CMD_LOOKUP, 32'sd0);
    send_word(CMD_DELETE, 32'sd5);
    send_word(CMD_UNUSED, 32'sd5);
    send_word(CMD_INSERT, 32'sh8000_0000);
    send_word(CMD_INSERT, 32'sh7FFF_FFFF);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_INSERT, -32'sd1);
    send_word(CMD_INSERT, 32'sh5555_5555);
    send_word(CMD_INSERT, 32'shAAAA_AAAA);
    send_word(CMD_INSERT, 32'sd0);
    send_word(CMD_LOOKUP, 32'sh7FFF_FFFF);
    send_word(CMD_LOOKUP, 32'sh7FFF_FFFE);
    send_word(CMD_UNUSED, -32'sd1);
    send_word(CMD_DELETE, 32'sh8000_0000);
    send_word(CMD_LOOKUP, 32'shAAAA_AAAA);
    send_word(CMD_DELETE, 32'shAAAA_AAAA);
    send_word(CMD_DELETE, 32'sh1234_5678);
  endtask

  task automatic test_full_table();
    for (int i = 0; table_count < TABLE_DEPTH; i++)
      send_word(CMD_INSERT, 32'h1000_0000 + i);
    send_word(CMD_INSERT, 32'sh0BAD_F00D);
    send_word(CMD_INSERT, 32'sh5555_5555);
    send_word(CMD_LOOKUP, table_slots[TABLE_DEPTH - 1]);
    send_word(CMD_DELETE, table_slots[3]);
    send_word(CMD_INSERT, 32'sh0BAD_F00D);
  endtask

  task automatic test_capacity_limits();
    write_capacity(32'hFFFF_FFE0);
    send_word(CMD_INSERT, 32'sh0000_0777);
    while (table_count > 0) send_word(CMD_DELETE, table_slots[0]);
    send_word(CMD_INSERT, 32'sh0000_0777);
    write_capacity(32'd1);
    send_word(CMD_INSERT, 32'sh0000_0777);
    send_word(CMD_INSERT, 32'sh0000_0778);
    write_capacity(32'd31);
    for (int i = 0; table_count < TABLE_DEPTH; i++)
      send_word(CMD_INSERT, $urandom);
    send_word(CMD_INSERT, 32'sh0000_0779);
    write_capacity(32'd4);
    send_word(CMD_INSERT, 32'sh0000_0779);
    while (table_count > 3) send_word(CMD_DELETE, table_slots[table_count - 1]);
    send_word(CMD_INSERT, 32'sh0000_0779);
    send_word(CMD_INSERT, 32'sh0000_077A);
  endtask

  task automatic test_random_traffic();
    logic [APB_DW-1:0] phase_caps [8];
    logic [CMD_W-1:0]  c;
    logic [VAL_W-1:0]  v;
    int                pick;
    phase_caps = '{32'd16, 32'd31, 32'd5, 32'd1, 32'd0, 32'd12, 32'd3, 32'd16};
    for (int p = 0; p < 8; p++) begin
      write_capacity(phase_caps[p]);
      quiet_sender = (p % 3 == 2);
      foreach (value_pool[k]) value_pool[k] = $urandom;
      value_pool[0] = 32'h8000_0000;
      value_pool[1] = 32'h7FFF_FFFF;
      value_pool[2] = 32'hFFFF_FFFF;
      value_pool[3] = 32'h0000_0000;
      for (int n = 0; n < 105; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      c = CMD_INSERT;
        else if (pick < 70) c = CMD_DELETE;
        else if (pick < 95) c = CMD_LOOKUP;
        else                c = CMD_UNUSED;
        if ($urandom_range(0, 99) < 85) v = value_pool[$urandom_range(0, 19)];
        else                            v = $urandom;
        send_word(c, v);
      end
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    int waited;
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd   = CMD_LOOKUP;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    sink_mode    = RDY_ALWAYS;
    sink_tick    = 0;
    stall_left   = 0;
    mismatches   = 0;
    burst_left   = 0;
    quiet_sender = 1'b0;
    table_count  = '0;
    capacity_reg = CAP_RESET;
    foreach (table_slots[k]) table_slots[k] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_basic_ops();
    test_full_table();
    test_capacity_limits();
    test_random_traffic();

    @(negedge clk);
    req_ch.valid = 1'b0;
    waited = 0;
    while (expected_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d result words never arrived", expected_results.size());
      mismatches++;
    end
    repeat (TABLE_DEPTH + 4) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
design/sst_pkg.sv
design/sst_req_if.sv
design/sst_rsp_if.sv
design/small_set_table_top.sv
sim/small_set_table_top_tb.sv
